// ===== sv/psvp_pkg.sv =====
// Shared types and constants for the point source visibility predictor.
// Used by psvp_front, psvp_fifo, psvp_back and the top level.
package psvp_pkg;

  localparam int CS_W = 34;            // cordic datapath width
  localparam int STG_W = 6;            // stage counter, covers up to 32 stages
  localparam int DIV_STEPS = 64;       // quotient bits per division
  localparam int DIV_CNT_W = 7;
  localparam int LANES = 8;            // 4 polarizations x real/imag
  localparam logic signed [CS_W-1:0] GAIN_INV = 34'sd652032874;
  localparam logic signed [31:0] ONE_Q30 = 32'sh40000000;

  typedef struct packed {
    logic signed [CS_W-1:0] c;
    logic signed [CS_W-1:0] s;
    logic [3:0][63:0]       bright;    // [0]=xx [1]=xy [2]=yx [3]=yy
    logic [30:0]            n;
    logic                   last;
  } job_t;

  typedef enum logic [2:0] {
    F_IDLE, F_MUL, F_SUM, F_ROT, F_PUSH
  } front_state_t;

  typedef enum logic [2:0] {
    B_IDLE, B_MUL, B_LOAD, B_DIV, B_ACC, B_EMIT
  } back_state_t;

  // atan(2^-i) in units of 2^-32 turn
  function automatic logic [31:0] atan_turn(input logic [4:0] i);
    logic [31:0] r;
    case (i)
      5'd0:  r = 32'h20000000;
      5'd1:  r = 32'h12E4051E;
      5'd2:  r = 32'h09FB385B;
      5'd3:  r = 32'h051111D4;
      5'd4:  r = 32'h028B0D43;
      5'd5:  r = 32'h0145D7E1;
      5'd6:  r = 32'h00A2F61E;
      5'd7:  r = 32'h00517C55;
      5'd8:  r = 32'h0028BE53;
      5'd9:  r = 32'h00145F2F;
      5'd10: r = 32'h000A2F98;
      5'd11: r = 32'h000517CC;
      5'd12: r = 32'h00028BE6;
      5'd13: r = 32'h000145F3;
      5'd14: r = 32'h0000A2FA;
      5'd15: r = 32'h0000517D;
      5'd16: r = 32'h000028BE;
      5'd17: r = 32'h0000145F;
      5'd18: r = 32'h00000A30;
      5'd19: r = 32'h00000518;
      5'd20: r = 32'h0000028C;
      5'd21: r = 32'h00000146;
      5'd22: r = 32'h000000A3;
      5'd23: r = 32'h00000051;
      5'd24: r = 32'h00000029;
      5'd25: r = 32'h00000014;
      5'd26: r = 32'h0000000A;
      5'd27: r = 32'h00000005;
      5'd28: r = 32'h00000003;
      5'd29: r = 32'h00000001;
      5'd30: r = 32'h00000001;
      default: r = 32'h00000000;
    endcase
    return r;
  endfunction

endpackage

// ===== sv/psvp_front.sv =====
// Front end: takes a source word, forms the phase and runs the CORDIC.
// Pushes cos/sin with the brightnesses into the job queue. Uses psvp_pkg.
module psvp_front #(
  parameter int CORDIC_STAGES = 24
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic signed [31:0] u_coord,
  input  logic signed [31:0] v_coord,
  input  logic signed [31:0] w_coord,
  input  logic signed [31:0] dir_l,
  input  logic signed [31:0] dir_m,
  input  logic [30:0]        dir_n,
  input  logic [63:0]        bright_xx,
  input  logic [63:0]        bright_xy,
  input  logic [63:0]        bright_yx,
  input  logic [63:0]        bright_yy,
  input  logic               last_source,
  output logic               push,
  output psvp_pkg::job_t     push_data,
  input  logic               full
);

  localparam int W = psvp_pkg::CS_W;
  localparam logic [psvp_pkg::STG_W-1:0] LAST_STG = psvp_pkg::STG_W'(CORDIC_STAGES - 1);

  psvp_pkg::front_state_t state, state_next;

  logic signed [31:0] u, v, w, l, m;
  logic [30:0]        n;
  logic [3:0][63:0]   bright;
  logic               last;
  logic signed [63:0] p_ul, p_vm, p_wn;
  logic signed [W-1:0] x, y, z;
  logic               flip;
  logic [psvp_pkg::STG_W-1:0] cnt;

  logic [63:0]        sum;
  logic [31:0]        phase, phase_f;
  logic signed [31:0] n_m1;
  logic signed [W-1:0] dx, dy, atn;

  assign in_stall = (state != psvp_pkg::F_IDLE);
  assign n_m1 = $signed({1'b0, n}) - psvp_pkg::ONE_Q30;
  assign sum = 64'(p_ul) + 64'(p_vm) + 64'(p_wn);
  assign phase = sum[37:6];
  assign phase_f = {phase[31] ^ (phase + 32'h40000000) >> 31 == 32'd1, phase[30:0]};
  assign dx = y >>> cnt[4:0];
  assign dy = x >>> cnt[4:0];
  assign atn = $signed({2'b00, psvp_pkg::atan_turn(cnt[4:0])});

  always_comb begin
    state_next = state;
    push = 1'b0;
    case (state)
      psvp_pkg::F_IDLE: if (in_valid) state_next = psvp_pkg::F_MUL;
      psvp_pkg::F_MUL:  state_next = psvp_pkg::F_SUM;
      psvp_pkg::F_SUM:  state_next = psvp_pkg::F_ROT;
      psvp_pkg::F_ROT:  if (cnt == LAST_STG) state_next = psvp_pkg::F_PUSH;
      psvp_pkg::F_PUSH: begin
        if (!full) begin
          push = 1'b1;
          state_next = psvp_pkg::F_IDLE;
        end
      end
      default: state_next = psvp_pkg::F_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= psvp_pkg::F_IDLE;
    else state <= state_next;
  end

  always_ff @(posedge clk) begin
    case (state)
      psvp_pkg::F_IDLE: begin
        if (in_valid) begin
          u <= u_coord; v <= v_coord; w <= w_coord;
          l <= dir_l; m <= dir_m; n <= dir_n;
          bright <= {bright_yy, bright_yx, bright_xy, bright_xx};
          last <= last_source;
        end
      end
      psvp_pkg::F_MUL: begin
        p_ul <= u * l;
        p_vm <= v * m;
        p_wn <= w * n_m1;
      end
      psvp_pkg::F_SUM: begin
        // phases in [1/4,3/4) turn are moved half a turn, result negated
        flip <= phase_f[31] != phase[31];
        x <= psvp_pkg::GAIN_INV;
        y <= '0;
        z <= W'($signed(phase_f));
        cnt <= '0;
      end
      psvp_pkg::F_ROT: begin
        if (!z[W-1]) begin
          x <= x - dx; y <= y + dy; z <= z - atn;
        end else begin
          x <= x + dx; y <= y - dy; z <= z + atn;
        end
        cnt <= cnt + 1'b1;
      end
      default: ;
    endcase
  end

  assign push_data.c = flip ? -x : x;
  assign push_data.s = flip ? -y : y;
  assign push_data.bright = bright;
  assign push_data.n = n;
  assign push_data.last = last;

endmodule

// ===== sv/psvp_fifo.sv =====
// Two-entry job queue between the phase front end and the accumulate back end.
// Uses psvp_pkg::job_t.
module psvp_fifo (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  psvp_pkg::job_t push_data,
  output logic           full,
  input  logic           pop,
  output psvp_pkg::job_t pop_data,
  output logic           empty
);

  psvp_pkg::job_t mem [2];
  logic       wp, rp;
  logic [1:0] count;

  assign full = (count == 2'd2);
  assign empty = (count == 2'd0);
  assign pop_data = mem[rp];

  always_ff @(posedge clk) begin
    if (push) mem[wp] <= push_data;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp <= 1'b0;
      rp <= 1'b0;
      count <= 2'd0;
    end else begin
      if (push) wp <= ~wp;
      if (pop) rp <= ~rp;
      count <= count + {1'b0, push} - {1'b0, pop};
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst) push |-> !full)
    else $error("queue push while full");
  a_no_underflow: assert property (@(posedge clk) disable iff (rst) pop |-> !empty)
    else $error("queue pop while empty");
  a_count_range: assert property (@(posedge clk) disable iff (rst) count != 2'd3)
    else $error("queue count out of range");

endmodule

// ===== sv/psvp_back.sv =====
// Back end: rotates brightnesses, divides by n (bit-serial, 8 lanes),
// accumulates with saturation and emits on the last source. Uses psvp_pkg.
module psvp_back #(
  parameter int ACC_BITS = 48
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           empty,
  output logic           pop,
  input  psvp_pkg::job_t pop_data,
  output logic           out_valid,
  input  logic           out_stall,
  output logic [63:0]    vis_xx,
  output logic [63:0]    vis_xy,
  output logic [63:0]    vis_yx,
  output logic [63:0]    vis_yy,
  output logic           saturated
);

  localparam int NL = psvp_pkg::LANES;
  localparam logic signed [65:0] ACC_HI = (66'sd1 <<< (ACC_BITS - 1)) - 66'sd1;
  localparam logic signed [65:0] ACC_LO = -ACC_HI - 66'sd1;
  localparam logic signed [65:0] O_HI = 66'sd2147483647;
  localparam logic signed [65:0] O_LO = -66'sd2147483648;

  psvp_pkg::back_state_t state, state_next;
  psvp_pkg::job_t job;

  logic signed [65:0] prod_a [NL];
  logic signed [65:0] prod_b [NL];
  logic [63:0]        mag [NL];
  logic [31:0]        rem [NL];
  logic               neg [NL];
  logic signed [ACC_BITS-1:0] acc [NL];
  logic               clip_seen;
  logic [psvp_pkg::DIV_CNT_W-1:0] cnt;

  logic [30:0] nd;
  logic        out_free;

  assign nd = (job.n == 31'd0) ? 31'd1 : job.n;
  assign out_free = !out_valid || !out_stall;
  assign pop = (state == psvp_pkg::B_IDLE) && !empty;

  always_comb begin
    state_next = state;
    case (state)
      psvp_pkg::B_IDLE: if (!empty) state_next = psvp_pkg::B_MUL;
      psvp_pkg::B_MUL:  state_next = psvp_pkg::B_LOAD;
      psvp_pkg::B_LOAD: state_next = psvp_pkg::B_DIV;
      psvp_pkg::B_DIV: begin
        if (cnt == psvp_pkg::DIV_CNT_W'(psvp_pkg::DIV_STEPS - 1)) state_next = psvp_pkg::B_ACC;
      end
      psvp_pkg::B_ACC: state_next = job.last ? psvp_pkg::B_EMIT : psvp_pkg::B_IDLE;
      psvp_pkg::B_EMIT: if (out_free) state_next = psvp_pkg::B_IDLE;
      default: state_next = psvp_pkg::B_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= psvp_pkg::B_IDLE;
    else state <= state_next;
  end

  // datapath lanes: lane k = polarization k/2, imag part when k is odd
  always_ff @(posedge clk) begin
    logic signed [31:0] re, im;
    logic signed [66:0] d;
    logic [32:0]        r2;
    if (pop) job <= pop_data;
    for (int k = 0; k < NL; k++) begin
      re = job.bright[k/2][63:32];
      im = job.bright[k/2][31:0];
      case (state)
        psvp_pkg::B_MUL: begin
          prod_a[k] <= re * ((k % 2 == 1) ? job.s : job.c);
          prod_b[k] <= im * ((k % 2 == 1) ? job.c : job.s);
        end
        psvp_pkg::B_LOAD: begin
          d = (k % 2 == 1) ? 67'(prod_a[k]) + 67'(prod_b[k])
                           : 67'(prod_a[k]) - 67'(prod_b[k]);
          neg[k] <= d[66];
          mag[k] <= d[66] ? 64'(-d) : d[63:0];
          rem[k] <= '0;
        end
        psvp_pkg::B_DIV: begin
          // restoring divide, quotient bits shift into mag
          r2 = {rem[k], mag[k][63]};
          if (r2 >= {2'b00, nd}) begin
            rem[k] <= 32'(r2 - {2'b00, nd});
            mag[k] <= {mag[k][62:0], 1'b1};
          end else begin
            rem[k] <= r2[31:0];
            mag[k] <= {mag[k][62:0], 1'b0};
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    logic signed [65:0] q, s;
    logic               hit;
    if (rst) begin
      for (int k = 0; k < NL; k++) acc[k] <= '0;
      clip_seen <= 1'b0;
      cnt <= '0;
    end else begin
      case (state)
        psvp_pkg::B_LOAD: cnt <= '0;
        psvp_pkg::B_DIV:  cnt <= cnt + 1'b1;
        psvp_pkg::B_ACC: begin
          hit = 1'b0;
          for (int k = 0; k < NL; k++) begin
            q = neg[k] ? -$signed({2'b00, mag[k]}) : $signed({2'b00, mag[k]});
            s = 66'(acc[k]) + q;
            if (s > ACC_HI) begin
              acc[k] <= ACC_BITS'(ACC_HI);
              hit = 1'b1;
            end else if (s < ACC_LO) begin
              acc[k] <= ACC_BITS'(ACC_LO);
              hit = 1'b1;
            end else begin
              acc[k] <= s[ACC_BITS-1:0];
            end
          end
          if (hit) clip_seen <= 1'b1;
        end
        psvp_pkg::B_EMIT: begin
          if (out_free) begin
            for (int k = 0; k < NL; k++) acc[k] <= '0;
            clip_seen <= 1'b0;
          end
        end
        default: ;
      endcase
    end
  end

  // output register, 32-bit clipping of each part
  always_ff @(posedge clk) begin
    logic [31:0] p32 [NL];
    logic        clip;
    logic signed [65:0] a;
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == psvp_pkg::B_EMIT && out_free) begin
      clip = clip_seen;
      for (int k = 0; k < NL; k++) begin
        a = 66'(acc[k]);
        if (a > O_HI) begin
          p32[k] = 32'h7FFFFFFF; clip = 1'b1;
        end else if (a < O_LO) begin
          p32[k] = 32'h80000000; clip = 1'b1;
        end else begin
          p32[k] = a[31:0];
        end
      end
      vis_xx <= {p32[0], p32[1]};
      vis_xy <= {p32[2], p32[3]};
      vis_yx <= {p32[4], p32[5]};
      vis_yy <= {p32[6], p32[7]};
      saturated <= clip;
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  a_div_bound: assert property (@(posedge clk) disable iff (rst)
    state == psvp_pkg::B_DIV |-> cnt < psvp_pkg::DIV_CNT_W'(psvp_pkg::DIV_STEPS))
    else $error("divider ran past its step count");
  a_emit_only_last: assert property (@(posedge clk) disable iff (rst)
    state == psvp_pkg::B_EMIT |-> job.last)
    else $error("emit without last source");
  a_clear_after_emit: assert property (@(posedge clk) disable iff (rst)
    state == psvp_pkg::B_EMIT && out_free |=> !clip_seen && acc[0] == '0)
    else $error("accumulators not cleared after emit");

endmodule

// ===== sv/point_source_visibility_predict.sv =====
// Path: the front end multiplies, sums and runs the CORDIC, then pushes to the queue;
// the back end multiplies, loads, runs the 64-step n divider, accumulates and emits
// to the output register. Each end holds one source at a time: the front stalls its
// input while busy, the back pops only when idle, and emit also waits on out_stall.
// Reset (rst, synchronous): accumulators, clip flag, queue and output valid cleared.
// Top level of the point source visibility predictor; uses psvp_pkg.
module point_source_visibility_predict #(
  parameter int CORDIC_STAGES = 24,
  parameter int ACC_BITS = 48
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic signed [31:0] u_coord,
  input  logic signed [31:0] v_coord,
  input  logic signed [31:0] w_coord,
  input  logic signed [31:0] dir_l,
  input  logic signed [31:0] dir_m,
  input  logic [30:0]        dir_n,
  input  logic [63:0]        bright_xx,
  input  logic [63:0]        bright_xy,
  input  logic [63:0]        bright_yx,
  input  logic [63:0]        bright_yy,
  input  logic               last_source,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [63:0]        vis_xx,
  output logic [63:0]        vis_xy,
  output logic [63:0]        vis_yx,
  output logic [63:0]        vis_yy,
  output logic               saturated
);

  logic           push, full, pop, empty;
  psvp_pkg::job_t push_data, pop_data;

  psvp_front #(.CORDIC_STAGES(CORDIC_STAGES)) u_front (
    .clk, .rst, .in_valid, .in_stall,
    .u_coord, .v_coord, .w_coord, .dir_l, .dir_m, .dir_n,
    .bright_xx, .bright_xy, .bright_yx, .bright_yy, .last_source,
    .push, .push_data, .full
  );

  psvp_fifo u_fifo (
    .clk, .rst, .push, .push_data, .full, .pop, .pop_data, .empty
  );

  psvp_back #(.ACC_BITS(ACC_BITS)) u_back (
    .clk, .rst, .empty, .pop, .pop_data,
    .out_valid, .out_stall, .vis_xx, .vis_xy, .vis_yx, .vis_yy, .saturated
  );

endmodule

// ===== dv/tb_top.sv =====
// Self-checking testbench for point_source_visibility_predict.
// Holds its own fixed-point predictor (phase, CORDIC, divide, saturating sums) and
// compares every emitted visibility word; depends on sv/psvp_pkg.sv and the top RTL.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int STAGES = 24;
  localparam int ACC_W = 48;
  localparam int N_RANDOM = 930;

  typedef struct {
    logic signed [31:0] u, v, w, l, m;
    logic [30:0]        n;
    logic [63:0]        br [4];
    logic               last;
  } source_t;

  typedef struct {
    logic [63:0] vis [4];
    logic        sat;
  } vis_t;

  localparam logic [31:0] ATAN_TURNS [32] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
    32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
    32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
    32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D,
    32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
    32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051,
    32'h00000029, 32'h00000014, 32'h0000000A, 32'h00000005,
    32'h00000003, 32'h00000001, 32'h00000001, 32'h00000000};

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  logic signed [31:0] u_coord = '0, v_coord = '0, w_coord = '0, dir_l = '0, dir_m = '0;
  logic [30:0] dir_n = '0;
  logic [63:0] bright_xx = '0, bright_xy = '0, bright_yx = '0, bright_yy = '0;
  logic last_source = 1'b0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [63:0] vis_xx, vis_xy, vis_yx, vis_yy;
  logic saturated;

  point_source_visibility_predict #(.CORDIC_STAGES(STAGES), .ACC_BITS(ACC_W)) u_top (
    .clk, .rst, .in_valid, .in_stall, .u_coord, .v_coord, .w_coord, .dir_l, .dir_m,
    .dir_n, .bright_xx, .bright_xy, .bright_yx, .bright_yy, .last_source,
    .out_valid, .out_stall, .vis_xx, .vis_xy, .vis_yx, .vis_yy, .saturated);

  initial forever #2 clk = ~clk;

  // predictor state
  longint acc_re [4];
  longint acc_im [4];
  bit     clip_sticky;

  source_t pending_sources [$];
  vis_t    expected_vis [$];
  int      mismatches = 0;
  int      sources_taken = 0;
  bit      stimulus_done = 0;

  function automatic longint add_clip(longint a, longint b, ref bit clipped);
    longint hi, lo, s;
    hi = (longint'(1) <<< (ACC_W - 1)) - 1;
    lo = -hi - 1;
    s = a + b;
    if (s > hi) begin
      clipped = 1;
      return hi;
    end
    if (s < lo) begin
      clipped = 1;
      return lo;
    end
    return s;
  endfunction

  function automatic logic [31:0] clip_word(longint v, ref bit clipped);
    if (v > 64'sd2147483647) begin
      clipped = 1;
      return 32'h7FFFFFFF;
    end
    if (v < -64'sd2147483648) begin
      clipped = 1;
      return 32'h80000000;
    end
    return v[31:0];
  endfunction

  // Accumulate one source; returns 1 and the visibility word on a last source.
  task automatic accumulate_source(input source_t s, output bit emit, output vis_t r);
    logic [63:0] phase_sum;
    logic [31:0] phase;
    longint x, y, z, dx, dy, nd, re, im, rr, ii;
    bit flip, clipped;
    phase_sum = 64'(longint'(s.u) * longint'(s.l)) + 64'(longint'(s.v) * longint'(s.m))
              + 64'(longint'(s.w) * (longint'({1'b0, s.n}) - 64'sd1073741824));
    phase = phase_sum[37:6];
    flip = 0;
    if ((phase + 32'h40000000) & 32'h80000000) begin
      phase ^= 32'h80000000;
      flip = 1;
    end
    x = 652032874;
    y = 0;
    z = longint'(signed'(phase));
    for (int i = 0; i < STAGES && i < 32; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        x -= dx; y += dy; z -= longint'(ATAN_TURNS[i]);
      end else begin
        x += dx; y -= dy; z += longint'(ATAN_TURNS[i]);
      end
    end
    if (flip) begin
      x = -x;
      y = -y;
    end
    nd = (s.n == 0) ? 1 : longint'({1'b0, s.n});
    for (int p = 0; p < 4; p++) begin
      re = longint'(signed'(s.br[p][63:32]));
      im = longint'(signed'(s.br[p][31:0]));
      rr = re * x - im * y;
      ii = re * y + im * x;
      acc_re[p] = add_clip(acc_re[p], rr / nd, clip_sticky);
      acc_im[p] = add_clip(acc_im[p], ii / nd, clip_sticky);
    end
    emit = s.last;
    if (emit) begin
      clipped = clip_sticky;
      for (int p = 0; p < 4; p++)
        r.vis[p] = {clip_word(acc_re[p], clipped), clip_word(acc_im[p], clipped)};
      r.sat = clipped;
      for (int p = 0; p < 4; p++) begin
        acc_re[p] = 0;
        acc_im[p] = 0;
      end
      clip_sticky = 0;
    end
  endtask

  function automatic source_t random_source(bit last);
    source_t s;
    int mode;
    mode = $urandom_range(0, 9);
    s.u = $urandom; s.v = $urandom; s.w = $urandom;
    if (mode == 0) begin
      // raw fields, outside the stated ranges too
      s.l = $urandom; s.m = $urandom; s.n = 31'($urandom);
    end else begin
      s.l = $urandom_range(0, 32'h80000000) - 32'sh40000000;
      s.m = $urandom_range(0, 32'h80000000) - 32'sh40000000;
      s.n = (mode == 1) ? 31'($urandom_range(0, 3)) : 31'($urandom_range(1, 32'h40000000));
      if (mode < 5) begin
        s.u = $signed(s.u) >>> $urandom_range(0, 20);
        s.v = $signed(s.v) >>> $urandom_range(0, 20);
        s.w = $signed(s.w) >>> $urandom_range(0, 20);
      end
    end
    for (int p = 0; p < 4; p++) begin
      s.br[p] = {$urandom, $urandom};
      if (mode > 3) begin
        s.br[p][63:32] = $signed(s.br[p][63:32]) >>> $urandom_range(4, 12);
        s.br[p][31:0] = $signed(s.br[p][31:0]) >>> $urandom_range(4, 12);
      end
    end
    s.last = last;
    return s;
  endfunction

  function automatic source_t make_source(logic signed [31:0] u, v, w, l, m,
                                          logic [30:0] n, logic [63:0] b, logic last);
    source_t s;
    s.u = u; s.v = v; s.w = w; s.l = l; s.m = m; s.n = n;
    for (int p = 0; p < 4; p++) s.br[p] = b ^ {p[1:0], 30'd0, p[1:0], 30'd0};
    s.last = last;
    return s;
  endfunction

  initial begin
    int left, grp;
    // directed: zero phase, extremes of coordinates and directions, n edge values
    pending_sources.push_back(make_source(0, 0, 0, 0, 0, 31'h40000000,
                                          {32'h01000000, 32'h0}, 1));
    pending_sources.push_back(make_source(32'h7FFFFFFF, 32'h80000000, 32'h7FFFFFFF,
                                          32'h40000000, -32'sh40000000, 31'd1,
                                          64'h0000100000001000, 0));
    pending_sources.push_back(make_source(32'h80000000, 32'h7FFFFFFF, 32'h80000000,
                                          -32'sh40000000, 32'h40000000, 31'h7FFFFFFF,
                                          64'hFFFFFFFF_FFFFFFFF, 1));
    // zero n saturates the sums
    pending_sources.push_back(make_source(256, 512, -256, 32'h20000000, 32'h10000000,
                                          31'd0, 64'h7FFFFFFF_80000000, 1));
    // output clipping to 32 bits without sum clipping
    for (int i = 0; i < 4; i++)
      pending_sources.push_back(make_source(0, 0, 0, 0, 0, 31'h40000000,
                                            64'h7FFFFFFF_80000000, i == 3));
    // quarter, half and three-quarter turn phases, then a phase from w alone
    pending_sources.push_back(make_source(32'd64, 0, 0, 32'h40000000, 0, 31'h40000000,
                                          {32'h01000000, 32'h00800000}, 1));
    pending_sources.push_back(make_source(32'd128, 0, 0, 32'h40000000, 0, 31'h40000000,
                                          {32'h01000000, 32'h00800000}, 1));
    pending_sources.push_back(make_source(32'd192, 0, 0, 32'h40000000, 0, 31'h40000000,
                                          {32'h80000000, 32'h7FFFFFFF}, 1));
    pending_sources.push_back(make_source(0, 0, 32'd100, 0, 0, 31'h20000000,
                                          {32'h00000001, 32'hFFFFFFFF}, 1));
    // accumulator clipping, then clean sum right after
    for (int i = 0; i < 3; i++)
      pending_sources.push_back(make_source(0, 0, 0, 0, 0, 31'd1,
                                            64'h7FFFFFFF_7FFFFFFF, i == 2));
    pending_sources.push_back(make_source(0, 0, 0, 0, 0, 31'h40000000, 64'h0, 1));
    // random groups, mostly short sums
    left = N_RANDOM;
    while (left > 0) begin
      grp = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 12) : $urandom_range(1, 4);
      if (grp > left) grp = left;
      for (int i = 0; i < grp; i++)
        pending_sources.push_back(random_source(i == grp - 1));
      left -= grp;
    end
  end

  initial begin
    for (int p = 0; p < 4; p++) begin
      acc_re[p] = 0;
      acc_im[p] = 0;
    end
    clip_sticky = 0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
  end

  // sender
  bit in_took = 0;
  int in_gap = 0;
  bit in_busy_mode = 1;
  always @(posedge clk) begin
    bit emit;
    bit took;
    vis_t r;
    took = 0;
    if (!rst && in_valid && !in_stall) begin
      source_t s;
      s.u = u_coord; s.v = v_coord; s.w = w_coord; s.l = dir_l; s.m = dir_m;
      s.n = dir_n; s.br[0] = bright_xx; s.br[1] = bright_xy; s.br[2] = bright_yx;
      s.br[3] = bright_yy; s.last = last_source;
      accumulate_source(s, emit, r);
      if (emit) expected_vis.push_back(r);
      sources_taken <= sources_taken + 1;
      took = 1;
    end
    in_took <= took;
  end

  always @(negedge clk) begin
    bit nv;
    source_t s;
    nv = in_valid;
    if (!rst) begin
      if (in_took) begin
        nv = 0;
        if (sources_taken % 64 == 0) in_busy_mode = $urandom_range(0, 2) != 0;
        in_gap = in_busy_mode ? $urandom_range(0, 6) : 0;
      end
      if (!nv) begin
        if (in_gap > 0) begin
          in_gap--;
        end else if (pending_sources.size() > 0) begin
          s = pending_sources.pop_front();
          u_coord <= s.u; v_coord <= s.v; w_coord <= s.w; dir_l <= s.l; dir_m <= s.m;
          dir_n <= s.n; bright_xx <= s.br[0]; bright_xy <= s.br[1];
          bright_yx <= s.br[2]; bright_yy <= s.br[3]; last_source <= s.last;
          nv = 1;
        end else begin
          stimulus_done = 1;
        end
      end
    end
    in_valid <= nv;
  end

  // receiver
  bit out_took = 0;
  int out_wait = 0;
  bit long_hold = 0;
  always @(posedge clk) begin
    bit took;
    vis_t e;
    took = 0;
    if (!rst && out_valid && !out_stall) begin
      took = 1;
      if (expected_vis.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("%0t: unexpected visibility word", $realtime);
      end else begin
        e = expected_vis.pop_front();
        if ({vis_xx, vis_xy, vis_yx, vis_yy, saturated} !==
            {e.vis[0], e.vis[1], e.vis[2], e.vis[3], e.sat}) begin
          mismatches++;
          if (mismatches <= 10)
            $display("%0t: mismatch exp %h %h %h %h sat %b got %h %h %h %h sat %b",
                     $realtime, e.vis[0], e.vis[1], e.vis[2], e.vis[3], e.sat,
                     vis_xx, vis_xy, vis_yx, vis_yy, saturated);
        end
      end
    end
    out_took <= took;
  end

  always @(negedge clk) begin
    if (out_took)
      out_wait = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 6);
    else if (out_wait > 0)
      out_wait--;
    out_stall <= long_hold || out_wait > 0;
  end

  // long hold-off so the block backs up and stalls its input
  initial begin
    wait (sources_taken >= 120);
    @(negedge clk);
    long_hold = 1;
    repeat (800) @(negedge clk);
    long_hold = 0;
  end

  initial begin
    wait (stimulus_done && !in_valid);
    wait (expected_vis.size() == 0);
    repeat (300) @(posedge clk);
    if (expected_vis.size() != 0) mismatches++;
    if (mismatches == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

  initial begin
    #4ms;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end
endmodule

// ===== point_source_visibility_predict.f =====
sv/psvp_pkg.sv
sv/psvp_front.sv
sv/psvp_fifo.sv
sv/psvp_back.sv
sv/point_source_visibility_predict.sv
dv/tb_top.sv
